>>> rtl/core/nonlinear_audio_stream_mixer_macros.svh
// Assertion macros used by the mix core of the audio stream mixer RTL.
`ifndef NONLINEAR_AUDIO_STREAM_MIXER_MACROS_SVH
`define NONLINEAR_AUDIO_STREAM_MIXER_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is high
`define NASM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included
`define NASM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/nasm_pkg.sv
// Types and constants of the audio stream mixer.
package nasm_pkg;

   // Stream count served by the mixer
   localparam int NUM_STREAMS = 8;

   // Sample limits and mix scaling
   localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
   localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
   localparam int                 MIX_SHIFT  = 15;

   // Accumulator range that the mix rule keeps to
   localparam logic signed [16:0] ACC_MAX = 17'sd32768;
   localparam logic signed [16:0] ACC_MIN = -17'sd32768;

   // Register file
   localparam int         CSR_ADDR_WIDTH  = 3;
   localparam int         MASK_WIDTH      = 8;
   localparam logic [MASK_WIDTH-1:0] MASK_RESET = 8'hFF;
   localparam logic [0:0] REG_STREAM_MASK = 1'b0;

   // One input request
   typedef struct packed {
      logic [2:0]         stream_index;
      logic signed [15:0] sample;
      logic               last_stream;
      logic               last_of_packet;
   } req_type;

   // One result
   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic               packet_end;
   } rsp_type;

endpackage

>>> rtl/core/nasm_csr.sv
// APB-style register block holding the stream enable mask.
module nasm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nasm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [nasm_pkg::MASK_WIDTH-1:0]    stream_enable_mask
);
   import nasm_pkg::*;

   logic [MASK_WIDTH-1:0] mask_ff;
   logic [MASK_WIDTH-1:0] mask_in;
   logic                  wr_en;
   logic                  sel_mask;

   // Register index is the word address
   assign sel_mask   = (csr_paddr[2] == REG_STREAM_MASK);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && sel_mask;
   assign csr_pready = 1'b1;

   always_comb begin
      mask_in = mask_ff;
      if (wr_en) begin
         mask_in = csr_pwdata[MASK_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // Read back; unmapped addresses read zero
   always_comb begin
      csr_prdata = '0;
      if (sel_mask) begin
         csr_prdata = {{(32-MASK_WIDTH){1'b0}}, mask_ff};
      end
   end

   assign stream_enable_mask = mask_ff;

endmodule

>>> rtl/core/nasm_mix_core.sv
// Input register, mix accumulator and per-request combine logic.
`include "nonlinear_audio_stream_mixer_macros.svh"

module nasm_mix_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nasm_pkg::req_type               req_payload,
   input  logic [nasm_pkg::MASK_WIDTH-1:0] stream_enable_mask,
   input  logic                            out_free,
   output logic                            out_load,
   output nasm_pkg::rsp_type               out_rsp
);
   import nasm_pkg::*;

   // Input register
   logic               in_valid_ff;
   logic               in_valid_in;
   req_type            in_req_ff;

   // Frame state
   logic signed [16:0] acc_ff;
   logic signed [16:0] acc_in;
   logic               empty_ff;
   logic               empty_in;

   logic               advance;
   logic               enabled;
   logic signed [16:0] a_val;
   logic signed [16:0] b_val;
   logic signed [32:0] prod;
   logic signed [17:0] sum;
   logic signed [17:0] term;
   logic signed [17:0] mix_wide;
   logic signed [16:0] acc_next;
   logic               empty_next;

   // Saturate the 17-bit mix to a 16-bit sample
   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      logic signed [15:0] r;
      r = v[15:0];
      if (v > $signed({SAMPLE_MAX[15], SAMPLE_MAX})) begin
         r = SAMPLE_MAX;
      end else if (v < $signed({SAMPLE_MIN[15], SAMPLE_MIN})) begin
         r = SAMPLE_MIN;
      end
      return r;
   endfunction

   // A frame-ending request waits until the result register frees up
   assign advance   = in_valid_ff && (!in_req_ff.last_stream || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
   end

   // Mix rule: soft-clip when signs agree, plain sum otherwise
   always_comb begin
      enabled  = stream_enable_mask[in_req_ff.stream_index] &&
                 (32'(in_req_ff.stream_index) < NUM_STREAMS);
      a_val    = acc_ff;
      b_val    = {in_req_ff.sample[15], in_req_ff.sample};
      prod     = $signed({{16{a_val[16]}}, a_val}) * $signed({{16{b_val[16]}}, b_val});
      term     = $signed(prod[32:MIX_SHIFT]);
      sum      = $signed({a_val[16], a_val}) + $signed({b_val[16], b_val});
      mix_wide = sum;
      if (!a_val[16] && !b_val[16]) begin
         mix_wide = sum - term;
      end else if (a_val[16] && b_val[16]) begin
         mix_wide = sum + term;
      end

      acc_next   = acc_ff;
      empty_next = empty_ff;
      if (enabled) begin
         empty_next = 1'b0;
         if (empty_ff) begin
            acc_next = b_val;
         end else begin
            acc_next = mix_wide[16:0];
         end
      end
   end

   // State update and result hand-off
   always_comb begin
      acc_in                 = acc_ff;
      empty_in               = empty_ff;
      out_load               = 1'b0;
      out_rsp.mixed_sample   = empty_next ? '0 : sat16(acc_next);
      out_rsp.packet_end     = in_req_ff.last_of_packet;
      if (advance) begin
         if (in_req_ff.last_stream) begin
            out_load = 1'b1;
            acc_in   = '0;
            empty_in = 1'b1;
         end else begin
            acc_in   = acc_next;
            empty_in = empty_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         empty_ff <= 1'b1;
      end else begin
         acc_ff   <= acc_in;
         empty_ff <= empty_in;
      end
   end

   `NASM_ASSERT(a_acc_range, (acc_ff >= ACC_MIN) && (acc_ff <= ACC_MAX), "accumulator out of mix range")
   `NASM_ASSERT(a_frame_restart, out_load |=> (empty_ff && (acc_ff == '0)), "frame state not cleared after result")
   `NASM_ASSERT(a_load_free, out_load |-> out_free, "result loaded into a busy output register")
   `NASM_ASSERT_RST(a_reset_state, reset |=> (!in_valid_ff && empty_ff), "state not cleared by reset")

endmodule

>>> rtl/core/nasm_out_reg.sv
// Result register between the mix logic and the result channel.
module nasm_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              out_load,
   input  nasm_pkg::rsp_type out_rsp,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nasm_pkg::rsp_type rsp_payload
);
   import nasm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   // Free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_rsp;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/nonlinear_audio_stream_mixer.sv
// Top level of the nonlinear audio stream mixer.
//
// Takes one stream sample per request, in stream order, and mixes the enabled
// streams of a frame into one saturated 16-bit sample, issued on the request
// that carries last_stream (0 when no stream of the frame was enabled). The
// block accepts one request every clock cycle while no frame-ending request is
// held; a request is registered in the input register and a frame-ending one
// then moves into the result register, which drives rsp_valid. A combinational
// 17x16 multiply and add combine a sample with the accumulator. When a result is
// still waiting in the result register, a frame-ending request holds in the
// input register and req_ready follows rsp_ready in that cycle. The enable mask
// sits at byte address 0 of the register port and resets to all streams enabled.
module nonlinear_audio_stream_mixer (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  nasm_pkg::req_type                  req_payload,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output nasm_pkg::rsp_type                  rsp_payload,
   // Register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nasm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import nasm_pkg::*;

   logic [MASK_WIDTH-1:0] stream_enable_mask;
   logic                  out_free;
   logic                  out_load;
   rsp_type               out_rsp;

   // Configuration registers
   nasm_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .stream_enable_mask (stream_enable_mask)
   );

   // Mix datapath
   nasm_mix_core u_mix_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload        (req_payload),
      .stream_enable_mask (stream_enable_mask),
      .out_free           (out_free),
      .out_load           (out_load),
      .out_rsp            (out_rsp)
   );

   // Result register
   nasm_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .out_load    (out_load),
      .out_rsp     (out_rsp),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the nonlinear audio stream mixer: predicted mixes against results.
module tb;
   import nasm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_ITEMS   = 240;

   // Predicts mixed samples and holds them until the block delivers them
   class mixer_scoreboard;
      logic [MASK_WIDTH-1:0] enable_mask;
      logic signed [16:0]    mix_acc;
      bit                    frame_empty;
      bit                    pkt_hold;
      rsp_type               expected_mix_q[$];
      int                    errors;

      function new();
         enable_mask = MASK_RESET;
         mix_acc     = '0;
         frame_empty = 1'b1;
         pkt_hold    = 1'b0;
         errors      = 0;
      endfunction

      function void set_mask(logic [MASK_WIDTH-1:0] value);
         enable_mask = value;
      endfunction

      function int pending();
         return expected_mix_q.size();
      endfunction

      // Nonlinear a+b-ab combine (a+b+ab for two negatives, a+b for mixed signs) of accumulator and sample
      function int combine_samples(int a, int b);
         if (a >= 0 && b >= 0)
            return a + b - ((a * b) >>> MIX_SHIFT);
         if (a < 0 && b < 0)
            return a + b + ((a * b) >>> MIX_SHIFT);
         return a + b;
      endfunction

      function void note_request(req_type r);
         int      acc_now;
         int      smp;
         int      clipped;
         bit      enabled;
         rsp_type mix_out;
         smp      = $signed(r.sample);
         enabled  = (int'(r.stream_index) < NUM_STREAMS) &&
                    (int'(r.stream_index) < MASK_WIDTH) && enable_mask[r.stream_index];
         pkt_hold = r.last_of_packet;
         if (enabled) begin
            if (frame_empty) begin
               mix_acc     = 17'(smp);
               frame_empty = 1'b0;
            end else begin
               acc_now = mix_acc;
               mix_acc = 17'(combine_samples(acc_now, smp));
            end
         end
         if (r.last_stream) begin
            acc_now = mix_acc;
            if (frame_empty)
               clipped = 0;
            else if (acc_now > SAMPLE_MAX)
               clipped = SAMPLE_MAX;
            else if (acc_now < SAMPLE_MIN)
               clipped = SAMPLE_MIN;
            else
               clipped = acc_now;
            mix_out.mixed_sample = 16'(clipped);
            mix_out.packet_end   = pkt_hold;
            expected_mix_q.push_back(mix_out);
            mix_acc     = '0;
            frame_empty = 1'b1;
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task check_result(rsp_type r);
         rsp_type want;
         if (expected_mix_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d/%0b",
                                      $signed(r.mixed_sample), r.packet_end));
         end else begin
            want = expected_mix_q.pop_front();
            if (r.mixed_sample !== want.mixed_sample)
               report_mismatch($sformatf("mixed_sample got %0d expected %0d",
                                         $signed(r.mixed_sample),
                                         $signed(want.mixed_sample)));
            if (r.packet_end !== want.packet_end)
               report_mismatch($sformatf("packet_end got %0b expected %0b",
                                         r.packet_end, want.packet_end));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_payload;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   mixer_scoreboard mix_sb;
   bit              quiet_phase = 1'b0;
   int              cycle_count = 0;

   nonlinear_audio_stream_mixer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Handshake monitor: predict on each accepted request, check each result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            mix_sb.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            mix_sb.check_result(rsp_payload);
      end
   end

   // Result receiver: short random stalls plus long hold-offs while requests are offered
   initial begin
      int rx_cycles;
      int next_hold;
      int holds_done;
      int burst;
      rx_cycles  = 0;
      next_hold  = 500;
      holds_done = 0;
      rsp_ready  = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset) begin
            rx_cycles++;
            if (!quiet_phase && holds_done < 2 && rx_cycles >= next_hold && req_valid) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_ready <= 1'b1;
               rx_cycles += HOLD_CYCLES;
               holds_done++;
               next_hold = rx_cycles + 1000;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               burst = $urandom_range(1, 3);
               rsp_ready <= 1'b0;
               repeat (burst) @(posedge clock);
               rsp_ready <= 1'b1;
               rx_cycles += burst;
            end
         end
      end
   end

   function automatic req_type make_req(int idx, logic signed [15:0] smp, bit last, bit pkt);
      req_type r;
      r.stream_index   = 3'(idx);
      r.sample         = smp;
      r.last_stream    = last;
      r.last_of_packet = pkt;
      return r;
   endfunction

   // Sample mix that favors the saturation corners
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return 16'sd0;
         3:       return -16'sd1;
         4:       return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request and wait for it to be taken
   task automatic send_request(input req_type r);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Let every expected result come out, then let the pipeline settle
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mix_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stream_mask(input logic [MASK_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(4 * REG_STREAM_MASK);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mix_sb.set_mask(value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One frame: ascending stream subset, or noise with arbitrary indices
   task automatic send_frame(input bit noisy, output int sent);
      int                    idx_list[$];
      logic [NUM_STREAMS-1:0] pick;
      bit                    last;
      bit                    pkt;
      if (noisy) begin
         repeat ($urandom_range(1, 6)) idx_list.push_back($urandom_range(0, 7));
      end else begin
         pick = NUM_STREAMS'($urandom_range(1, 255));
         for (int k = 0; k < NUM_STREAMS; k++)
            if (pick[k]) idx_list.push_back(k);
      end
      foreach (idx_list[i]) begin
         last = (i == idx_list.size() - 1);
         pkt  = last ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
         send_request(make_req(idx_list[i], pick_sample(), last, pkt));
      end
      sent = idx_list.size();
   endtask

   // Stimulus
   initial begin
      int                    sent;
      int                    phase_count;
      logic [MASK_WIDTH-1:0] phase_mask;
      mix_sb      = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: positive saturation, negative corner, mixed signs
      send_request(make_req(0, SAMPLE_MAX, 0, 0));
      send_request(make_req(1, SAMPLE_MAX, 1, 1));
      send_request(make_req(0, SAMPLE_MIN, 0, 1));
      send_request(make_req(1, SAMPLE_MIN, 1, 0));
      send_request(make_req(0, SAMPLE_MAX, 0, 0));
      send_request(make_req(1, SAMPLE_MIN, 1, 0));
      // single-stream frame
      send_request(make_req(5, 16'sd0, 1, 1));
      // full eight-stream frame
      send_request(make_req(0, 16'sd1000, 0, 0));
      send_request(make_req(1, -16'sd2000, 0, 0));
      send_request(make_req(2, 16'sd16384, 0, 0));
      send_request(make_req(3, 16'sd16384, 0, 0));
      send_request(make_req(4, -16'sd1, 0, 0));
      send_request(make_req(5, 16'sd1, 0, 0));
      send_request(make_req(6, 16'sh5555, 0, 0));
      send_request(make_req(7, 16'shAAAA, 1, 1));
      // indices out of order
      send_request(make_req(7, 16'sd20000, 0, 0));
      send_request(make_req(2, 16'sd20000, 1, 0));
      // every stream disabled still yields a zero result
      settle_idle();
      write_stream_mask(8'h00);
      send_request(make_req(3, 16'sd1234, 1, 1));
      // mask rewritten in the middle of a frame
      settle_idle();
      write_stream_mask(8'hFF);
      send_request(make_req(0, 16'sd12000, 0, 0));
      send_request(make_req(1, -16'sd5000, 0, 0));
      settle_idle();
      write_stream_mask(8'hFD);
      send_request(make_req(1, 16'sd9999, 0, 0));
      send_request(make_req(2, 16'sd8000, 1, 1));

      // Random phases, each under its own mask; the last runs without idling
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       phase_mask = 8'h00;
            1:       phase_mask = 8'hFF;
            2:       phase_mask = 8'h01;
            3:       phase_mask = 8'h80;
            7:       phase_mask = 8'hFF;
            default: phase_mask = MASK_WIDTH'($urandom_range(0, 255));
         endcase
         settle_idle();
         write_stream_mask(phase_mask);
         if (phase == 7)
            quiet_phase = 1'b1;
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            send_frame($urandom_range(0, 9) == 0, sent);
            phase_count += sent;
         end
         // sometimes leave a frame open across the next mask write
         if (phase < 7 && $urandom_range(0, 1) == 1) begin
            for (int k = 0; k < $urandom_range(1, 3); k++)
               send_request(make_req(k, pick_sample(), 0, 1'($urandom_range(0, 1))));
         end
      end

      settle_idle();
      if (mix_sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
